/* src/smx_pkg.sv */
// ============================================================================
// smx_pkg - shared types and constants of the stack machine executor
// Opcodes, control state encoding, stream payload widths and the request
// bundle sent to the multiply/divide unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

    // Payload field widths fixed by the instruction format
    localparam int OP_W       = 3;
    localparam int IMM_W      = 32;
    localparam int LOG_W      = 32;
    localparam int S_TDATA_W  = 40;   // op + immediate, padded to whole bytes
    localparam int M_TDATA_W  = 32;
    localparam int IMM_LSB    = OP_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_LOG  = 3'd5,
        OP_POP  = 3'd6,
        OP_HALT = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ARITH
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage : smx_pkg

`default_nettype wire

/* src/smx_ram.sv */
// ============================================================================
// smx_ram - generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : smx_ram

`default_nettype wire

/* src/smx_muldiv.sv */
// ============================================================================
// smx_muldiv - iterative multiply / signed divide unit
// Multiply retires one 16-bit digit of the multiplier per cycle; divide is a
// restoring radix-2 divider on magnitudes, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module smx_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire smx_pkg::md_req_t      req,
    input  wire logic [DATA_WIDTH-1:0] opa,     // below
    input  wire logic [DATA_WIDTH-1:0] opb,     // top
    output logic                       done,
    output logic      [DATA_WIDTH-1:0] result
);

    localparam int W    = DATA_WIDTH;
    localparam int MD   = (W < 16) ? W : 16;
    localparam int NMUL = (W + MD - 1) / MD;
    localparam int CW   = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          is_div_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  a_reg;      // multiplicand, or dividend/quotient shift
    logic [W-1:0]  b_reg;      // multiplier, or divisor magnitude
    logic [W:0]    rem_reg;
    logic          neg_reg;
    logic          zero_reg;

    logic [W+MD-1:0] prod;
    logic [W-1:0]    acc_next;
    logic [W:0]      rem_sh;
    logic [W:0]      diff;
    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;

    always_comb
    begin
        prod     = a_reg * b_reg[MD-1:0];
        acc_next = acc_reg + prod[W-1:0];
        rem_sh   = {rem_reg[W-1:0], a_reg[W-1]};
        diff     = rem_sh - {1'b0, b_reg};
        mag_a    = opa[W-1] ? (~opa + 1'b1) : opa;
        mag_b    = opb[W-1] ? (~opb + 1'b1) : opb;
    end

    // Control: step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.is_div ? CW'(W) : CW'(NMUL);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            is_div_reg <= req.is_div;
            acc_reg    <= '0;
            rem_reg    <= '0;
            neg_reg    <= opa[W-1] ^ opb[W-1];
            zero_reg   <= (opb == '0);
            if (req.is_div)
            begin
                a_reg <= mag_a;
                b_reg <= mag_b;
            end
            else
            begin
                a_reg <= opa;
                b_reg <= opb;
            end
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!diff[W])
                begin
                    rem_reg <= diff;
                    a_reg   <= {a_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    a_reg   <= {a_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                acc_reg <= acc_next;
                a_reg   <= a_reg << MD;
                b_reg   <= b_reg >> MD;
            end
        end
    end

    always_comb
    begin
        done = done_reg;
        if (!is_div_reg)
        begin
            result = acc_reg;
        end
        else if (zero_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = ~a_reg + 1'b1;
        end
        else
        begin
            result = a_reg;
        end
    end

endmodule : smx_muldiv

`default_nettype wire

/* src/stack_machine_executor.sv */
// ============================================================================
// stack_machine_executor - stack machine instruction executor
// Executes one instruction per input beat against a stack held in RAM.
// ============================================================================
// Push, pop and halt retire at acceptance; add, sub and log first read the
// top and below entries from RAM, then execute and write back in the
// execute state; mul and div start the iterative multiply/divide unit from
// the execute state and write back when it signals done. A log beat is
// registered onto m_tvalid from the execute state; a log that finds the previous
// beat still stalled holds the input off until that beat drains. Reset clears the
// stack pointer to empty (STACK_DEPTH-1) and the halt flag; stack contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_executor #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Instruction stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [smx_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] op, [34:3] immediate
    // Log stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [smx_pkg::M_TDATA_W-1:0] m_tdata    // [31:0] logged_value
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [AW-1:0] TOP_LAST = AW'(STACK_DEPTH - 1);

    smx_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   top_reg, top_next;
    logic            halted_reg, halted_next;
    smx_pkg::op_t    op_reg;
    logic            out_valid_reg;
    logic [smx_pkg::LOG_W-1:0] out_data_reg;

    smx_pkg::op_t    op_in;
    logic [DATA_WIDTH-1:0] imm_ext;
    logic            accept;
    logic [AW-1:0]   top_up;
    logic [AW-1:0]   top_down;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [DATA_WIDTH-1:0] top_data;
    logic [DATA_WIDTH-1:0] below_data;

    smx_pkg::md_req_t      md_req;
    logic                  md_done;
    logic [DATA_WIDTH-1:0] md_result;

    logic out_free;
    logic load_out;

    // Decode the input beat; the immediate is sign-extended or cut to the data width
    assign op_in   = smx_pkg::op_t'(s_tdata[smx_pkg::OP_W-1:0]);
    assign imm_ext = DATA_WIDTH'(signed'(s_tdata[smx_pkg::IMM_LSB +: smx_pkg::IMM_W]));

    assign s_tready = (state_reg == smx_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Stack pointer wraps modulo the depth, which need not be a power of two
    assign top_up   = (top_reg == TOP_LAST) ? '0 : top_reg + 1'b1;
    assign top_down = (top_reg == '0) ? TOP_LAST : top_reg - 1'b1;

    // Output register frees when empty or drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    // Two mirrored RAM copies give the top and below entries from the same read.
    // Reads are issued only at acceptance and writes land before the next
    // acceptance, so no forwarding is needed.
    smx_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram_top (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (top_reg),
        .rd_data (top_data)
    );

    smx_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram_below (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (top_down),
        .rd_data (below_data)
    );

    smx_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .opa    (below_data),
        .opb    (top_data),
        .done   (md_done),
        .result (md_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smx_pkg::ST_IDLE;
            top_reg       <= TOP_LAST;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            halted_reg <= halted_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_in;
        end
        if (load_out)
        begin
            out_data_reg <= smx_pkg::LOG_W'(top_data);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        halted_next = halted_reg;
        wr_en       = 1'b0;
        wr_addr     = top_up;
        wr_data     = imm_ext;
        rd_en       = 1'b0;
        md_req      = '0;
        load_out    = 1'b0;

        case (state_reg)
            smx_pkg::ST_IDLE:
            begin
                // Once halted, keep taking beats and drop them
                if (accept && !halted_reg)
                begin
                    case (op_in)
                        smx_pkg::OP_PUSH:
                        begin
                            wr_en    = 1'b1;
                            top_next = top_up;
                        end
                        smx_pkg::OP_POP:
                        begin
                            top_next = top_down;
                        end
                        smx_pkg::OP_HALT:
                        begin
                            halted_next = 1'b1;
                        end
                        smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
                        smx_pkg::OP_DIV, smx_pkg::OP_LOG:
                        begin
                            rd_en      = 1'b1;
                            state_next = smx_pkg::ST_EXEC;
                        end
                        default:
                        begin
                            state_next = smx_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            smx_pkg::ST_EXEC:
            begin
                wr_addr = top_down;
                case (op_reg)
                    smx_pkg::OP_ADD:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = below_data + top_data;
                        top_next   = top_down;
                        state_next = smx_pkg::ST_IDLE;
                    end
                    smx_pkg::OP_SUB:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = below_data - top_data;
                        top_next   = top_down;
                        state_next = smx_pkg::ST_IDLE;
                    end
                    smx_pkg::OP_MUL, smx_pkg::OP_DIV:
                    begin
                        md_req.start  = 1'b1;
                        md_req.is_div = (op_reg == smx_pkg::OP_DIV);
                        state_next    = smx_pkg::ST_ARITH;
                    end
                    smx_pkg::OP_LOG:
                    begin
                        // Hold here while the previous log beat is still stalled
                        if (out_free)
                        begin
                            load_out   = 1'b1;
                            state_next = smx_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = smx_pkg::ST_IDLE;
                    end
                endcase
            end

            smx_pkg::ST_ARITH:
            begin
                wr_addr = top_down;
                wr_data = md_result;
                if (md_done)
                begin
                    wr_en      = 1'b1;
                    top_next   = top_down;
                    state_next = smx_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = smx_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : stack_machine_executor

`default_nettype wire

/* src/smx_checker.sv */
// ============================================================================
// smx_checker - port-level checks of the stack machine executor
// Watches the instruction and log streams and flags handshake or sequencing
// violations.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module smx_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [smx_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [smx_pkg::M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled log beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("log beat dropped or changed while stalled");

    // A new log beat only comes out of the execute cycle, where input is held off
    a_log_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("log beat appeared without an execute cycle");

    // Halt retires at acceptance and the block keeps taking beats
    a_halt_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[smx_pkg::OP_W-1:0] == smx_pkg::OP_HALT)
        |=> s_tready)
        else $error("input stalled after halt");

    // Halt cannot produce a log beat
    a_halt_no_log: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[smx_pkg::OP_W-1:0] == smx_pkg::OP_HALT)
        |=> !$rose(m_tvalid))
        else $error("log beat raised after halt");

endmodule : smx_checker

bind stack_machine_executor smx_checker u_smx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* test/testbench.sv */
// ============================================================================
// testbench - self-checking bench for the stack machine executor
// Streams instructions into the executor and keeps its own copy of the stack,
// the stack pointer and the halt flag. Every log beat on the output stream is
// checked against the value that this copy predicts. The stimulus never reads
// a stack entry that has not been written. The run covers directed arithmetic
// corner cases, stack pointer wrap in both directions, back-to-back traffic,
// random traffic with idle cycles on both sides, a long output stall, and halt.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_WIDTH  = 32;
    localparam int IMM_W       = smx_pkg::IMM_W;
    localparam int LOG_W       = smx_pkg::LOG_W;
    localparam int PAD_W       = smx_pkg::S_TDATA_W - smx_pkg::IMM_W - smx_pkg::OP_W;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [smx_pkg::S_TDATA_W-1:0]  s_tdata  = '0;   // [2:0] op, [34:3] immediate
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [smx_pkg::M_TDATA_W-1:0]  m_tdata;         // [31:0] logged_value

    initial
    begin
        forever #4 clk = ~clk;
    end

    stack_machine_executor #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Shadow machine: stack contents, which entries hold a value, pointer, halt.
    // The 8-bit pointer wraps modulo the stack depth by itself.
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
    bit                    written   [STACK_DEPTH];
    logic [7:0]            top_ptr = 8'hFF;   // all ones means empty
    bit                    halted  = 1'b0;

    logic [LOG_W-1:0]      logged_q [$];      // log values still to come out

    int  err_count   = 0;
    int  instr_count = 0;
    int  log_count   = 0;
    int  div_count   = 0;
    int  mul_count   = 0;

    // Idle controls of the sender task and the receiver process
    bit  src_idle_en  = 1'b1;
    bit  sink_idle_en = 1'b1;
    int  hold_req     = 0;
    int  hold_left    = 0;

    // Signed divide: truncate toward zero, a zero operand gives zero, and the
    // most negative value over minus one wraps back to itself.
    function automatic logic [DATA_WIDTH-1:0] trunc_div(
        input logic [DATA_WIDTH-1:0] num,
        input logic [DATA_WIDTH-1:0] den);
        logic [DATA_WIDTH-1:0] mag_n;
        logic [DATA_WIDTH-1:0] mag_d;
        logic [DATA_WIDTH-1:0] quo;
        if (num == '0 || den == '0)
            return '0;
        mag_n = num[DATA_WIDTH-1] ? -num : num;
        mag_d = den[DATA_WIDTH-1] ? -den : den;
        quo   = mag_n / mag_d;
        return (num[DATA_WIDTH-1] != den[DATA_WIDTH-1]) ? -quo : quo;
    endfunction

    // Advance the shadow machine by one instruction; flag a log value if any.
    function automatic void apply_instr(
        input  smx_pkg::op_t     op,
        input  logic [IMM_W-1:0] imm,
        output bit               has_log,
        output logic [LOG_W-1:0] log_val);
        logic [7:0]            below_ptr;
        logic [DATA_WIDTH-1:0] lhs;
        logic [DATA_WIDTH-1:0] rhs;
        logic [DATA_WIDTH-1:0] res;
        has_log = 1'b0;
        log_val = '0;
        if (halted)
            return;
        below_ptr = top_ptr - 8'd1;
        lhs       = stack_mem[below_ptr];
        rhs       = stack_mem[top_ptr];
        case (op)
            smx_pkg::OP_PUSH:
            begin
                top_ptr            = top_ptr + 8'd1;
                stack_mem[top_ptr] = imm;
                written[top_ptr]   = 1'b1;
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV:
            begin
                case (op)
                    smx_pkg::OP_ADD: res = lhs + rhs;
                    smx_pkg::OP_SUB: res = lhs - rhs;
                    smx_pkg::OP_MUL: res = lhs * rhs;
                    default:         res = trunc_div(lhs, rhs);
                endcase
                if (op == smx_pkg::OP_DIV)
                    div_count++;
                if (op == smx_pkg::OP_MUL)
                    mul_count++;
                stack_mem[below_ptr] = res;
                written[below_ptr]   = 1'b1;
                top_ptr              = below_ptr;
            end
            smx_pkg::OP_LOG:
            begin
                has_log = 1'b1;
                log_val = rhs;
            end
            smx_pkg::OP_POP:
                top_ptr = below_ptr;
            default:
                halted = 1'b1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender: called at a falling edge, returns at a falling edge. Leave
    // s_tvalid high on return so back-to-back beats need no extra cycle.
    // ------------------------------------------------------------------------
    task automatic send_instr(input smx_pkg::op_t op, input logic [IMM_W-1:0] imm);
        bit               has_log;
        logic [LOG_W-1:0] log_val;
        while (src_idle_en && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, imm, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Beat accepted at this edge: predict now, in order of acceptance
        apply_instr(op, imm, has_log, log_val);
        if (has_log)
            logged_q.push_back(log_val);
        instr_count++;
        @(negedge clk);
    endtask

    // Operand mix: full range, small magnitudes, and the edge values
    function automatic logic [IMM_W-1:0] random_operand();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return IMM_W'($signed($urandom_range(8)) - 4);
            2:
            begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    // One random instruction that only reads written entries; never halt.
    task automatic send_random(input int log_pct);
        int           pick;
        smx_pkg::op_t op;
        bit           top_ok;
        bit           pair_ok;
        top_ok  = written[top_ptr];
        pair_ok = top_ok && written[top_ptr - 8'd1];
        pick    = $urandom_range(99);
        if (pick < log_pct)
            op = smx_pkg::OP_LOG;
        else if (pick < log_pct + 12)
            op = smx_pkg::OP_POP;
        else if (pick < log_pct + 30)
            op = smx_pkg::op_t'($urandom_range(int'(smx_pkg::OP_ADD), int'(smx_pkg::OP_DIV)));
        else
            op = smx_pkg::OP_PUSH;
        // Fall back to a push where the operands would be unwritten
        if (op == smx_pkg::OP_LOG && !top_ok)
            op = smx_pkg::OP_PUSH;
        if (op inside {smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV}
            && !pair_ok)
            op = smx_pkg::OP_PUSH;
        send_instr(op, random_operand());
    endtask

    // ------------------------------------------------------------------------
    // Receiver: drive m_tready at the falling edge. A requested hold-off
    // keeps ready low until its count runs out; otherwise idle at random.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !(sink_idle_en && $urandom_range(99) < 34);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare every accepted log beat with the oldest prediction
    // ------------------------------------------------------------------------
    logic [LOG_W-1:0] want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (logged_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: log beat 0x%08h with nothing expected",
                             $realtime, m_tdata);
            end
            else
            begin
                want = logged_q.pop_front();
                log_count++;
                if (m_tdata !== want)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: logged_value mismatch: expected 0x%08h, got 0x%08h",
                                 $realtime, want, m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Wrapping add, most negative over minus one, zero divisor, zero
    // dividend, truncation toward zero, multiply and wrapping subtract.
    task automatic test_directed_arith();
        send_instr(smx_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0001);
        send_instr(smx_pkg::OP_ADD,  32'hFFFF_FFFF);   // immediate ignored
        send_instr(smx_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_instr(smx_pkg::OP_DIV,  32'h0000_0000);
        send_instr(smx_pkg::OP_LOG,  32'h5A5A_A5A5);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0000);
        send_instr(smx_pkg::OP_DIV,  32'h0000_0000);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0009);
        send_instr(smx_pkg::OP_DIV,  32'h0000_0000);
        send_instr(smx_pkg::OP_LOG,  32'h0000_0000);
        send_instr(smx_pkg::OP_PUSH, -32'sd7);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0002);
        send_instr(smx_pkg::OP_DIV,  32'h0000_0000);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0003);
        send_instr(smx_pkg::OP_MUL,  32'h0000_0000);
        send_instr(smx_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_instr(smx_pkg::OP_SUB,  32'h0000_0000);
        send_instr(smx_pkg::OP_LOG,  32'h0000_0000);
        send_instr(smx_pkg::OP_POP,  32'h0000_0000);
    endtask

    // Pop below entry zero, then push back up across the top of the stack.
    task automatic test_stack_wrap();
        send_instr(smx_pkg::OP_POP,  32'h0000_0000);
        send_instr(smx_pkg::OP_POP,  32'h0000_0000);
        send_instr(smx_pkg::OP_POP,  32'h0000_0000);
        send_instr(smx_pkg::OP_PUSH, 32'hC0DE_0001);
        send_instr(smx_pkg::OP_PUSH, 32'hC0DE_0002);
        send_instr(smx_pkg::OP_PUSH, 32'hC0DE_0003);
        send_instr(smx_pkg::OP_LOG,  32'h0000_0000);
    endtask

    // Neither side idles: the block runs at its own pace.
    task automatic test_back_to_back();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (300)
            send_random(20);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        repeat (1480)
            send_random(20);
    endtask

    // Hold the output off for a long stretch while log-heavy traffic keeps
    // coming, so the block fills up and stalls its input.
    task automatic test_output_backpressure();
        hold_req = 300;
        send_instr(smx_pkg::OP_PUSH, random_operand());
        repeat (60)
            send_random(60);
    endtask

    // After halt every opcode is dropped without effect.
    task automatic test_halt();
        send_instr(smx_pkg::OP_HALT, $urandom());
        for (int op_code = int'(smx_pkg::OP_PUSH); op_code <= int'(smx_pkg::OP_HALT); op_code++)
            send_instr(smx_pkg::op_t'(op_code), $urandom());
        send_instr(smx_pkg::OP_LOG, $urandom());
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_arith();
        test_stack_wrap();
        test_back_to_back();
        test_random_traffic();
        test_output_backpressure();
        test_halt();

        // Drain pending log beats, then let any divide still in flight finish
        while (logged_q.size() != 0)
            @(posedge clk);
        repeat (64)
            @(posedge clk);

        $display("Sent %0d instructions (%0d divides, %0d multiplies)",
                 instr_count, div_count, mul_count);
        $display("and checked %0d logged values, including stack wrap, a 300-cycle output",
                 log_count);
        $display("stall and instructions after halt.");
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
